/* rtl/assert_macros.svh */
// Assertion macros for the rotated subpixel writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define RSW_ASSERT_ON(lbl, ck, rst_n, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define RSW_ASSERT(lbl, prop, msg) \
	`RSW_ASSERT_ON(lbl, clk, arst_n, prop, msg)

`endif

/* rtl/rsw_pkg.sv */
// Types, register map, subpixel codes and palette tables of the rotated subpixel writer.
`default_nettype none
package rsw_pkg;

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_CMAP_MODE     = 3'd0;
	localparam reg_idx_t REG_SCREEN_WIDTH  = 3'd1;
	localparam reg_idx_t REG_SCREEN_HEIGHT = 3'd2;
	localparam reg_idx_t REG_LINE_STRIDE   = 3'd3;
	localparam reg_idx_t REG_FRAME_BASE    = 3'd4;

	localparam logic [11:0] RST_SCREEN_WIDTH  = 12'd320;
	localparam logic [11:0] RST_SCREEN_HEIGHT = 12'd240;
	localparam logic [13:0] RST_LINE_STRIDE   = 14'd320;

	typedef struct packed {
		logic        cmap_mode;
		logic [11:0] screen_width;
		logic [11:0] screen_height;
		logic [13:0] line_stride;
		logic [31:0] frame_base;
	} cfg_t;

	// Bytes of one queued pixel; byte0 is the red byte or the palette index.
	typedef struct packed {
		logic       pal;
		logic [7:0] byte0;
		logic [7:0] grn;
		logic [7:0] blu;
	} ent_ctrl_t;

	typedef enum logic [1:0] {
		SUB_RED   = 2'd0,
		SUB_GRN   = 2'd1,
		SUB_BLU   = 2'd2,
		SUB_BLACK = 2'd3
	} sub_t;

	localparam logic [2:0] STEP_LAST     = 3'd7;
	localparam logic [2:0] STEP_PAL_LAST = 3'd4;
	localparam logic [2:0] STEP_RGB_INC  = 3'd1;
	localparam logic [2:0] STEP_PAL_INC  = 3'd4;

	localparam logic [7:0] BLACK_BYTE = 8'h01;
	localparam logic [7:0] PAL_ZERO_SUB = 8'h01;

	localparam logic [7:0] RED_TAB [6] = '{8'h01, 8'hA1, 8'hA2, 8'hA3, 8'hA4, 8'h03};
	localparam logic [7:0] GRN_TAB [5] = '{8'h01, 8'hB1, 8'hCA, 8'hC7, 8'hC8};
	localparam logic [7:0] BLU_TAB [5] = '{8'h01, 8'hB1, 8'hCD, 8'hCC, 8'h20};

	// Rounded quotient by 42, clamped to 5, found by threshold compares.
	function automatic logic [7:0] quant_red(input logic [7:0] c);
		logic [2:0] q;
		if (c >= 8'd189) q = 3'd5;
		else if (c >= 8'd147) q = 3'd4;
		else if (c >= 8'd105) q = 3'd3;
		else if (c >= 8'd63) q = 3'd2;
		else if (c >= 8'd21) q = 3'd1;
		else q = 3'd0;
		return RED_TAB[q];
	endfunction

	// Rounded quotient by 51, clamped to 4.
	function automatic logic [2:0] quant_51(input logic [7:0] c);
		logic [2:0] q;
		if (c >= 8'd179) q = 3'd4;
		else if (c >= 8'd128) q = 3'd3;
		else if (c >= 8'd77) q = 3'd2;
		else if (c >= 8'd26) q = 3'd1;
		else q = 3'd0;
		return q;
	endfunction

	function automatic logic [7:0] quant_grn(input logic [7:0] c);
		return GRN_TAB[quant_51(c)];
	endfunction

	function automatic logic [7:0] quant_blu(input logic [7:0] c);
		return BLU_TAB[quant_51(c)];
	endfunction

endpackage
`default_nettype wire

/* rtl/rotated_subpixel_writer.sv */
// Top level of the rotated subpixel writer: register port, front pipeline, queue and write sequencer.
//
// Each pixel taken on start produces its byte writes one per cycle on write_valid:
// eight writes in RGB mode, two in palette mode, none when it falls out of bounds.
// The receiver cannot stall, so every write appears for exactly one cycle. The single
// write port sets the sustained rate, since a pixel's writes all pass through it before
// the next pixel's first write. A two-entry queue and two front stages absorb bursts,
// and busy rises only when all of them are full.
`default_nettype none
module rotated_subpixel_writer #(
	parameter int ADDR_WIDTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [23:0] pixel_value,
	input  wire logic [9:0]  game_col,
	input  wire logic [9:0]  game_row,
	output logic             write_valid,
	output logic [31:0]      write_address,
	output logic [7:0]       write_byte,
	output logic             last_write
);

	localparam int QW = $bits(rsw_pkg::ent_ctrl_t) + 2 * ADDR_WIDTH;

	rsw_pkg::cfg_t      cfg_q;
	rsw_pkg::reg_idx_t  reg_idx;
	logic               cfg_wr;

	logic               push;
	logic               pop;
	logic               full;
	logic               empty;
	rsw_pkg::ent_ctrl_t push_ctrl;
	logic [ADDR_WIDTH-1:0] push_base;
	logic [ADDR_WIDTH-1:0] push_wh;
	logic [QW-1:0]      head;
	rsw_pkg::ent_ctrl_t head_ctrl;
	logic [ADDR_WIDTH-1:0] head_base;
	logic [ADDR_WIDTH-1:0] head_wh;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cmap_mode     <= 1'b0;
			cfg_q.screen_width  <= rsw_pkg::RST_SCREEN_WIDTH;
			cfg_q.screen_height <= rsw_pkg::RST_SCREEN_HEIGHT;
			cfg_q.line_stride   <= rsw_pkg::RST_LINE_STRIDE;
			cfg_q.frame_base    <= 32'd0;
		end else if (cfg_wr) begin
			case (reg_idx)
				rsw_pkg::REG_CMAP_MODE:     cfg_q.cmap_mode     <= pwdata[0];
				rsw_pkg::REG_SCREEN_WIDTH:  cfg_q.screen_width  <= pwdata[11:0];
				rsw_pkg::REG_SCREEN_HEIGHT: cfg_q.screen_height <= pwdata[11:0];
				rsw_pkg::REG_LINE_STRIDE:   cfg_q.line_stride   <= pwdata[13:0];
				rsw_pkg::REG_FRAME_BASE:    cfg_q.frame_base    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			rsw_pkg::REG_CMAP_MODE:     prdata = 32'(cfg_q.cmap_mode);
			rsw_pkg::REG_SCREEN_WIDTH:  prdata = 32'(cfg_q.screen_width);
			rsw_pkg::REG_SCREEN_HEIGHT: prdata = 32'(cfg_q.screen_height);
			rsw_pkg::REG_LINE_STRIDE:   prdata = 32'(cfg_q.line_stride);
			rsw_pkg::REG_FRAME_BASE:    prdata = cfg_q.frame_base;
			default:                    prdata = 32'd0;
		endcase
	end

	rsw_front #(
		.AW(ADDR_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.start      (start),
		.pixel_value(pixel_value),
		.game_col   (game_col),
		.game_row   (game_row),
		.full       (full),
		.busy       (busy),
		.push       (push),
		.ent_ctrl   (push_ctrl),
		.ent_base   (push_base),
		.ent_wh     (push_wh)
	);

	rsw_queue #(
		.W(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data({push_ctrl, push_wh, push_base}),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	assign {head_ctrl, head_wh, head_base} = head;

	rsw_back #(
		.AW(ADDR_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.ctrl         (head_ctrl),
		.base         (head_base),
		.wh           (head_wh),
		.stride       (cfg_q.line_stride),
		.pop          (pop),
		.write_valid  (write_valid),
		.write_address(write_address),
		.write_byte   (write_byte),
		.last_write   (last_write)
	);

endmodule
`default_nettype wire

/* rtl/rsw_front.sv */
// Front pipeline: takes pixels, checks bounds, quantizes and forms the canvas address base.
`default_nettype none
module rsw_front #(
	parameter int AW = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rsw_pkg::cfg_t      cfg,
	input  wire logic               start,
	input  wire logic [23:0]        pixel_value,
	input  wire logic [9:0]         game_col,
	input  wire logic [9:0]         game_row,
	input  wire logic               full,
	output logic                    busy,
	output logic                    push,
	output rsw_pkg::ent_ctrl_t      ent_ctrl,
	output logic [AW-1:0]           ent_base,
	output logic [AW-1:0]           ent_wh
);

	logic        valid_s1;
	logic [23:0] pix_s1;
	logic [9:0]  col_s1;
	logic [9:0]  row_s1;

	logic              valid_s2;
	rsw_pkg::ent_ctrl_t ctrl_s2;
	logic [24:0]       ls_s2;
	logic [23:0]       wh_s2;
	logic [10:0]       b_s2;

	logic [10:0] line_c;
	logic [10:0] bidx_c;
	logic        inb_c;
	logic [24:0] ls_c;
	logic [23:0] wh_c;
	rsw_pkg::ent_ctrl_t ctrl_c;
	logic        stall_s2;

	logic [63:0] fb64;
	logic [63:0] wh64;
	logic [63:0] ls64;
	logic [63:0] b64;

	assign stall_s2 = valid_s2 && full;
	assign busy     = valid_s1 && stall_s2;
	assign push     = valid_s2 && !full;

	always_comb begin
		if (cfg.cmap_mode) begin
			line_c = {1'b0, col_s1};
			bidx_c = {1'b0, row_s1};
		end else begin
			line_c = {col_s1, 1'b0};
			bidx_c = {row_s1, 1'b0};
		end
		inb_c = ({1'b0, bidx_c} <= cfg.screen_width) && ({1'b0, line_c} <= cfg.screen_height);
		ls_c  = 25'(line_c) * 25'(cfg.line_stride);
		wh_c  = 24'(cfg.screen_width) * 24'(cfg.screen_height);
		ctrl_c.pal = cfg.cmap_mode;
		if (cfg.cmap_mode) begin
			ctrl_c.byte0 = (pix_s1[7:0] == 8'd0) ? rsw_pkg::PAL_ZERO_SUB : pix_s1[7:0];
		end else begin
			ctrl_c.byte0 = rsw_pkg::quant_red(pix_s1[23:16]);
		end
		ctrl_c.grn = rsw_pkg::quant_grn(pix_s1[15:8]);
		ctrl_c.blu = rsw_pkg::quant_blu(pix_s1[7:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (start && !busy) begin
			valid_s1 <= 1'b1;
		end else if (!stall_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			pix_s1 <= pixel_value;
			col_s1 <= game_col;
			row_s1 <= game_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall_s2) begin
			valid_s2 <= valid_s1 && inb_c;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_s2) begin
			ctrl_s2 <= ctrl_c;
			ls_s2   <= ls_c;
			wh_s2   <= wh_c;
			b_s2    <= bidx_c;
		end
	end

	assign fb64 = 64'(cfg.frame_base);
	assign wh64 = 64'(wh_s2);
	assign ls64 = 64'(ls_s2);
	assign b64  = 64'(b_s2);

	assign ent_ctrl = ctrl_s2;
	assign ent_wh   = wh64[AW-1:0];
	assign ent_base = fb64[AW-1:0] + wh64[AW-1:0] - ls64[AW-1:0] + b64[AW-1:0];

endmodule
`default_nettype wire

/* rtl/rsw_queue.sv */
// Two-entry queue between the front pipeline and the write sequencer.
`default_nettype none
module rsw_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] push_data,
	input  wire logic         pop,
	output logic [W-1:0]      head,
	output logic              full,
	output logic              empty
);

	logic [W-1:0] mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

/* rtl/rsw_back.sv */
// Write sequencer: steps through the canvas writes of the queued pixel, one per cycle.
`default_nettype none
`include "assert_macros.svh"
module rsw_back #(
	parameter int AW = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               empty,
	input  wire rsw_pkg::ent_ctrl_t ctrl,
	input  wire logic [AW-1:0]      base,
	input  wire logic [AW-1:0]      wh,
	input  wire logic [13:0]        stride,
	output logic                    pop,
	output logic                    write_valid,
	output logic [31:0]             write_address,
	output logic [7:0]              write_byte,
	output logic                    last_write
);

	logic [2:0]      step_q;
	rsw_pkg::sub_t   sub;
	logic            dl;
	logic            db;
	logic            last_c;
	logic [AW-1:0]   addr_c;
	logic [63:0]     addr64;
	logic [63:0]     stride64;
	logic [7:0]      byte_c;

	assign sub      = rsw_pkg::sub_t'(step_q[1:0]);
	assign dl       = (sub == rsw_pkg::SUB_GRN) || (sub == rsw_pkg::SUB_BLACK);
	assign db       = (sub == rsw_pkg::SUB_BLU) || (sub == rsw_pkg::SUB_BLACK);
	assign last_c   = (step_q == rsw_pkg::STEP_LAST) ||
	                  (ctrl.pal && step_q == rsw_pkg::STEP_PAL_LAST);
	assign pop      = !empty && last_c;
	assign stride64 = 64'(stride);
	assign addr_c   = base + (step_q[2] ? wh : {AW{1'b0}})
	                - (dl ? stride64[AW-1:0] : {AW{1'b0}}) + AW'(db);
	assign addr64   = 64'(addr_c);

	always_comb begin
		case (sub)
			rsw_pkg::SUB_RED:   byte_c = ctrl.byte0;
			rsw_pkg::SUB_GRN:   byte_c = ctrl.grn;
			rsw_pkg::SUB_BLU:   byte_c = ctrl.blu;
			rsw_pkg::SUB_BLACK: byte_c = rsw_pkg::BLACK_BYTE;
			default:            byte_c = rsw_pkg::BLACK_BYTE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd0;
			write_valid <= 1'b0;
			last_write  <= 1'b0;
		end else begin
			write_valid <= !empty;
			last_write  <= pop;
			if (pop) begin
				step_q <= 3'd0;
			end else if (!empty) begin
				step_q <= step_q + (ctrl.pal ? rsw_pkg::STEP_PAL_INC : rsw_pkg::STEP_RGB_INC);
			end
		end
	end

	always_ff @(posedge clk) begin
		write_address <= addr64[31:0];
		write_byte    <= byte_c;
	end

	`RSW_ASSERT(a_step_idle, empty |-> (step_q == 3'd0), "write step not at start while queue empty")
	`RSW_ASSERT(a_pal_steps, (!empty && ctrl.pal) |-> (step_q == 3'd0 || step_q == rsw_pkg::STEP_PAL_LAST), "palette item at an RGB-only step")
	`RSW_ASSERT(a_pop_last, pop |=> (write_valid && last_write), "item retired without a final write")
	`RSW_ASSERT(a_last_strobe, last_write |-> write_valid, "last_write without a write strobe")

endmodule
`default_nettype wire
